// ===== rtl/rlpm_pkg.sv =====
package rlpm_pkg;

  localparam int ADDR_W  = 32;
  localparam int INDEX_W = 4;
  localparam int PORT_W  = 3;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_RUN,
    SCAN_DONE
  } scan_state_t;

  typedef struct packed {
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] mask;
    logic [ADDR_W-1:0] gateway;
    logic [PORT_W-1:0] port;
  } route_entry_t;

  typedef struct packed {
    logic         valid;
    route_entry_t entry;
  } route_read_t;

  typedef struct packed {
    logic               hit;
    logic [INDEX_W-1:0] index;
    logic [ADDR_W-1:0]  gateway;
    logic [PORT_W-1:0]  port;
  } lookup_result_t;

endpackage

// ===== rtl/rlpm_table.sv =====
module rlpm_table
  import rlpm_pkg::*;
#(
  parameter  int ENTRIES = 16,
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic         wr_valid,
  input  route_entry_t wr_entry,
  input  logic         rd_en,
  input  logic [AW-1:0] rd_addr,
  output route_read_t  rd_data
);

  route_entry_t       route_mem [ENTRIES];
  route_entry_t       rd_entry_r;
  logic               rd_valid_r;
  logic [ENTRIES-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      route_mem[wr_addr] <= wr_entry;
    end
    if (rd_en) begin
      rd_entry_r <= route_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr_en) begin
        valid_r[wr_addr] <= wr_valid;
      end
      if (rd_en) begin
        rd_valid_r <= valid_r[rd_addr];
      end
    end
  end

  assign rd_data.valid = rd_valid_r;
  assign rd_data.entry = rd_entry_r;

endmodule

// ===== rtl/rlpm_scan.sv =====
module rlpm_scan
  import rlpm_pkg::*;
#(
  parameter  int ENTRIES = 16,
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [ADDR_W-1:0] start_addr,
  input  route_read_t       rd_data,
  input  logic              res_take,
  output logic              idle,
  output logic              rd_en,
  output logic [AW-1:0]     rd_addr,
  output logic              res_valid,
  output lookup_result_t    res
);

  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  scan_state_t       state_r, state_nxt;
  logic [AW-1:0]     idx_r;
  logic [AW-1:0]     idx_inc;
  logic [ADDR_W-1:0] addr_r;
  logic              best_found_r, best_found_nxt;
  logic [ADDR_W-1:0] best_mask_r, best_mask_nxt;
  logic [AW-1:0]     best_idx_r, best_idx_nxt;
  logic [ADDR_W-1:0] best_gw_r, best_gw_nxt;
  logic [PORT_W-1:0] best_port_r, best_port_nxt;
  logic              match;
  logic              better;

  assign idx_inc = idx_r + AW'(1);

  always_comb begin
    match  = rd_data.valid &&
             (((rd_data.entry.dest ^ addr_r) & rd_data.entry.mask) == '0);
    better = match && (!best_found_r || (rd_data.entry.mask > best_mask_r));
    best_found_nxt = best_found_r;
    best_mask_nxt  = best_mask_r;
    best_idx_nxt   = best_idx_r;
    best_gw_nxt    = best_gw_r;
    best_port_nxt  = best_port_r;
    if (better) begin
      best_found_nxt = 1'b1;
      best_mask_nxt  = rd_data.entry.mask;
      best_idx_nxt   = idx_r;
      best_gw_nxt    = rd_data.entry.gateway;
      best_port_nxt  = rd_data.entry.port;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= SCAN_IDLE;
      best_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (start) begin
        best_found_r <= 1'b0;
      end else if (state_r == SCAN_RUN) begin
        best_found_r <= best_found_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      addr_r <= start_addr;
      idx_r  <= '0;
    end else if (state_r == SCAN_RUN) begin
      idx_r       <= idx_inc;
      best_mask_r <= best_mask_nxt;
      best_idx_r  <= best_idx_nxt;
      best_gw_r   <= best_gw_nxt;
      best_port_r <= best_port_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      SCAN_IDLE: begin
        if (start) begin
          state_nxt = (ENTRIES == 1) ? SCAN_DONE : SCAN_RUN;
        end
      end
      SCAN_RUN: begin
        if (idx_inc == LAST) begin
          state_nxt = SCAN_DONE;
        end
      end
      SCAN_DONE: begin
        if (res_take) begin
          state_nxt = SCAN_IDLE;
        end
      end
      default: state_nxt = SCAN_IDLE;
    endcase
  end

  always_comb begin
    idle      = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = idx_inc;
    res_valid = 1'b0;
    case (state_r)
      SCAN_IDLE: begin
        idle    = 1'b1;
        rd_en   = 1'b1;
        rd_addr = '0;
      end
      SCAN_RUN: begin
        rd_en = 1'b1;
      end
      SCAN_DONE: begin
        res_valid = 1'b1;
      end
      default: idle = 1'b0;
    endcase
  end

  always_comb begin
    res = '0;
    if (best_found_nxt) begin
      res.hit     = 1'b1;
      res.index   = INDEX_W'(best_idx_nxt);
      res.gateway = best_gw_nxt;
      res.port    = best_port_nxt;
    end
  end

  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> idle)
    else $error("lookup started while scan busy");

  a_start_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> !idle)
    else $error("scan did not leave idle after start");

  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res_take |=> res_valid && $stable(res))
    else $error("pending result changed while not taken");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.hit |-> res.index == '0 && res.gateway == '0 && res.port == '0)
    else $error("miss result carries non-zero fields");

endmodule

// ===== rtl/route_longest_prefix_match_unit.sv =====
// IPv4 longest-prefix-match routing table.
// Input channel (in_valid / in_stall): one word per item. A write word
// (in_opcode = 0) loads slot in_entry_index with prefix, mask, gateway,
// port and valid mark and gives no result; slots at or beyond
// ROUTE_ENTRIES are dropped. A lookup word (in_opcode = 1) gives
// exactly one result word on the out_ channel.
// A lookup walks the table memory one slot per cycle through its single
// read port, then passes its result to the output register. in_stall is
// high from the accepted lookup until that result is taken, so no new
// word, write or lookup, is accepted while a lookup is in progress.
// The winner is the valid matching slot with the numerically greatest
// mask, lowest slot on a tie; a zero mask matches every address.
// Reset clears all valid marks at once and empties the result register;
// slot contents are undefined until written and need no clearing pass.
// A result waits in the output register while out_stall is high; a
// following lookup runs meanwhile and holds its own result until the
// register frees.
module route_longest_prefix_match_unit
  import rlpm_pkg::*;
#(
  parameter int ROUTE_ENTRIES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [INDEX_W-1:0] in_entry_index,
  input  logic               in_entry_valid,
  input  logic [ADDR_W-1:0]  in_dest_prefix,
  input  logic [ADDR_W-1:0]  in_prefix_mask,
  input  logic [ADDR_W-1:0]  in_next_hop,
  input  logic [PORT_W-1:0]  in_egress_port,
  input  logic [ADDR_W-1:0]  in_lookup_addr,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [INDEX_W-1:0] out_match_index,
  output logic [ADDR_W-1:0]  out_match_gateway,
  output logic [PORT_W-1:0]  out_match_port
);

  localparam int AW    = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;
  localparam int EXT_W = 9;

  logic           accept;
  logic           wr_en;
  logic           lookup_start;
  logic [EXT_W-1:0] idx_ext;
  logic [AW-1:0]  wr_addr;
  route_entry_t   wr_entry;
  route_read_t    rd_data;
  logic           rd_en;
  logic [AW-1:0]  rd_addr;
  logic           scan_idle;
  logic           res_valid;
  logic           res_take;
  lookup_result_t res;
  logic           out_valid_r;
  lookup_result_t out_r;

  assign in_stall     = !scan_idle;
  assign accept       = in_valid && !in_stall;
  assign idx_ext      = EXT_W'(in_entry_index);
  assign wr_addr      = AW'(idx_ext);
  assign wr_en        = accept && (in_opcode == OP_WRITE) &&
                        (idx_ext < EXT_W'(ROUTE_ENTRIES));
  assign lookup_start = accept && (in_opcode == OP_LOOKUP);

  assign wr_entry.dest    = in_dest_prefix;
  assign wr_entry.mask    = in_prefix_mask;
  assign wr_entry.gateway = in_next_hop;
  assign wr_entry.port    = in_egress_port;

  rlpm_table #(
    .ENTRIES (ROUTE_ENTRIES)
  ) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_valid (in_entry_valid),
    .wr_entry (wr_entry),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  rlpm_scan #(
    .ENTRIES (ROUTE_ENTRIES)
  ) u_scan (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (lookup_start),
    .start_addr (in_lookup_addr),
    .rd_data    (rd_data),
    .res_take   (res_take),
    .idle       (scan_idle),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .res_valid  (res_valid),
    .res        (res)
  );

  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_hit           = out_r.hit;
  assign out_match_index   = out_r.index;
  assign out_match_gateway = out_r.gateway;
  assign out_match_port    = out_r.port;

endmodule

// ===== test/route_longest_prefix_match_unit_test.sv =====
`timescale 1ns / 100ps

module route_longest_prefix_match_unit_test;
  import rlpm_pkg::*;

  localparam int ROUTES = 16;
  localparam int CYCLE_LIMIT = 1000000;

  typedef struct {
    bit                 drain;
    int                 gap;
    opcode_t            op;
    logic [INDEX_W-1:0] index;
    logic               valid;
    logic [ADDR_W-1:0]  dest;
    logic [ADDR_W-1:0]  mask;
    logic [ADDR_W-1:0]  gateway;
    logic [PORT_W-1:0]  port;
    logic [ADDR_W-1:0]  addr;
  } route_word_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_opcode = 1'b0;
  logic [INDEX_W-1:0] in_entry_index = '0;
  logic               in_entry_valid = 1'b0;
  logic [ADDR_W-1:0]  in_dest_prefix = '0;
  logic [ADDR_W-1:0]  in_prefix_mask = '0;
  logic [ADDR_W-1:0]  in_next_hop = '0;
  logic [PORT_W-1:0]  in_egress_port = '0;
  logic [ADDR_W-1:0]  in_lookup_addr = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_hit;
  logic [INDEX_W-1:0] out_match_index;
  logic [ADDR_W-1:0]  out_match_gateway;
  logic [PORT_W-1:0]  out_match_port;

  route_longest_prefix_match_unit #(
    .ROUTE_ENTRIES(ROUTES)
  ) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_opcode(in_opcode),
    .in_entry_index(in_entry_index),
    .in_entry_valid(in_entry_valid),
    .in_dest_prefix(in_dest_prefix),
    .in_prefix_mask(in_prefix_mask),
    .in_next_hop(in_next_hop),
    .in_egress_port(in_egress_port),
    .in_lookup_addr(in_lookup_addr),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_hit(out_hit),
    .out_match_index(out_match_index),
    .out_match_gateway(out_match_gateway),
    .out_match_port(out_match_port)
  );

  route_entry_t   fib [ROUTES];
  logic           fib_valid [ROUTES];
  logic [ADDR_W-1:0] plan_dest [ROUTES];
  logic [ADDR_W-1:0] plan_mask [ROUTES];

  route_word_t    route_words [$];
  lookup_result_t route_answers_q [$];
  route_word_t    on_wire;
  route_word_t    next_word;
  bit             staged = 1'b0;
  int             gap_left = 0;
  int             stall_left = 0;
  int             words_total = 0;
  int             words_taken = 0;
  int             mismatches = 0;
  int             cycle_count = 0;
  bit             no_gaps = 1'b0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    for (int i = 0; i < ROUTES; i++) fib_valid[i] = 1'b0;
  end

  function automatic lookup_result_t resolve_route(logic [ADDR_W-1:0] addr);
    lookup_result_t    best;
    logic [ADDR_W-1:0] best_mask;
    bit                found;
    best = '0;
    best_mask = '0;
    found = 1'b0;
    for (int i = 0; i < ROUTES; i++) begin
      if (fib_valid[i] && ((fib[i].dest & fib[i].mask) == (addr & fib[i].mask)) &&
          (!found || fib[i].mask > best_mask)) begin
        found = 1'b1;
        best_mask = fib[i].mask;
        best.hit = 1'b1;
        best.index = INDEX_W'(i);
        best.gateway = fib[i].gateway;
        best.port = fib[i].port;
      end
    end
    return best;
  endfunction

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 1;
    if (r < 85) return $urandom_range(2, 4);
    if (r < 97) return $urandom_range(5, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ADDR_W-1:0] rand_mask();
    int r;
    int len;
    r = $urandom_range(0, 99);
    if (r < 6) return '0;
    if (r < 12) return '1;
    if (r < 22) return $urandom;
    len = (r < 60) ? 8 * $urandom_range(1, 3) : $urandom_range(1, 31);
    return ~32'h0 << (32 - len);
  endfunction

  task automatic queue_word(route_word_t w);
    w.gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : idle_len();
    route_words.push_back(w);
    words_total++;
  endtask

  task automatic queue_write(int idx, logic valid, logic [ADDR_W-1:0] dest,
                             logic [ADDR_W-1:0] mask, logic [ADDR_W-1:0] gateway,
                             logic [PORT_W-1:0] port);
    route_word_t w;
    w.drain = 1'b0;
    w.op = OP_WRITE;
    w.index = INDEX_W'(idx);
    w.valid = valid;
    w.dest = dest;
    w.mask = mask;
    w.gateway = gateway;
    w.port = port;
    w.addr = $urandom;
    plan_dest[idx] = dest;
    plan_mask[idx] = mask;
    queue_word(w);
  endtask

  task automatic queue_lookup(logic [ADDR_W-1:0] addr);
    route_word_t w;
    w.drain = 1'b0;
    w.op = OP_LOOKUP;
    w.index = INDEX_W'($urandom_range(0, ROUTES - 1));
    w.valid = 1'(($urandom));
    w.dest = $urandom;
    w.mask = $urandom;
    w.gateway = $urandom;
    w.port = PORT_W'($urandom);
    w.addr = addr;
    queue_word(w);
  endtask

  task automatic queue_hold();
    route_word_t w;
    w = '{op: OP_WRITE, default: '0};
    w.drain = 1'b1;
    route_words.push_back(w);
  endtask

  task automatic report_mismatch(string what, logic [ADDR_W-1:0] got,
                                 logic [ADDR_W-1:0] want);
    $display("mismatch on %s: got %h, expected %h", what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin : drive_words
    bit taken;
    bit drive;
    taken = in_valid && !in_stall;
    drive = 1'b0;
    if (rst_n) begin
      if (taken) begin
        words_taken++;
        if (on_wire.op == OP_WRITE) begin
          fib_valid[on_wire.index] = on_wire.valid;
          fib[on_wire.index].dest = on_wire.dest;
          fib[on_wire.index].mask = on_wire.mask;
          fib[on_wire.index].gateway = on_wire.gateway;
          fib[on_wire.index].port = on_wire.port;
        end else begin
          route_answers_q.push_back(resolve_route(on_wire.addr));
        end
      end
      // hold the word until taken
      if (!in_valid || taken) begin
        if (!staged && route_words.size() > 0) begin
          next_word = route_words.pop_front();
          staged = 1'b1;
          gap_left = next_word.gap;
        end
        if (staged) begin
          if (next_word.drain) begin
            if (route_answers_q.size() == 0) staged = 1'b0;
          end else if (gap_left > 0) begin
            gap_left--;
          end else begin
            drive = 1'b1;
            staged = 1'b0;
            on_wire = next_word;
          end
        end
        in_valid <= drive;
        if (drive) begin
          in_opcode <= next_word.op;
          in_entry_index <= next_word.index;
          in_entry_valid <= next_word.valid;
          in_dest_prefix <= next_word.dest;
          in_prefix_mask <= next_word.mask;
          in_next_hop <= next_word.gateway;
          in_egress_port <= next_word.port;
          in_lookup_addr <= next_word.addr;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (route_answers_q.size() == 0) begin
        report_mismatch("unexpected result word", out_match_gateway, '0);
      end else begin
        want = route_answers_q.pop_front();
        if (out_hit !== want.hit)
          report_mismatch("hit", ADDR_W'(out_hit), ADDR_W'(want.hit));
        if (out_match_index !== want.index)
          report_mismatch("match_index", ADDR_W'(out_match_index), ADDR_W'(want.index));
        if (out_match_gateway !== want.gateway)
          report_mismatch("match_gateway", out_match_gateway, want.gateway);
        if (out_match_port !== want.port)
          report_mismatch("match_port", ADDR_W'(out_match_port), ADDR_W'(want.port));
      end
    end
    if (stall_left == 0 && (cycle_count % 4096) >= 1024 && $urandom_range(0, 3) == 0)
      stall_left = idle_len();
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int                slot;
    int                r;
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] base;

    for (int i = 0; i < ROUTES; i++) begin
      if (i == 0) queue_write(i, 1'b0, '0, '0, '0, '0);
      else if (i == ROUTES - 1) queue_write(i, 1'b0, '1, '1, '1, '1);
      else queue_write(i, 1'b0, $urandom, '1, $urandom, PORT_W'(i));
    end
    queue_lookup(32'h0000_0000);
    queue_write(15, 1'b1, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 3'd7);
    queue_write(2, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'hC0A8_0101, 3'd1);
    queue_write(6, 1'b1, 32'hC0A8_0100, 32'hFFFF_FF00, 32'h0A00_0001, 3'd2);
    queue_write(9, 1'b1, 32'hC0A8_0142, 32'hFFFF_FFFF, 32'h0A00_0002, 3'd3);
    queue_write(4, 1'b1, 32'h0A0F_00F0, 32'hF0F0_F0F0, 32'h0A00_0003, 3'd4);
    queue_write(0, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000, 3'd0);
    queue_lookup(32'hC0A8_0142);
    queue_lookup(32'hC0A8_0143);
    queue_lookup(32'h0F0A_0BF5);
    queue_lookup(32'h0808_0808);
    queue_lookup(32'hFFFF_FFFF);
    queue_write(9, 1'b0, 32'hC0A8_0142, 32'hFFFF_FFFF, 32'h0A00_0002, 3'd3);
    queue_lookup(32'hC0A8_0142);
    queue_hold();

    for (int k = 0; k < 1620; k++) begin
      no_gaps = (k % 300) < 60;
      if (k % 400 == 399) queue_hold();
      if ($urandom_range(0, 99) < 30) begin
        slot = $urandom_range(0, ROUTES - 1);
        base = $urandom;
        if ($urandom_range(0, 2) == 0) base = plan_dest[$urandom_range(0, ROUTES - 1)];
        queue_write(slot, $urandom_range(0, 99) < 80, base, rand_mask(), $urandom,
                    PORT_W'($urandom_range(0, 7)));
      end else begin
        r = $urandom_range(0, 99);
        slot = $urandom_range(0, ROUTES - 1);
        addr = (plan_dest[slot] & plan_mask[slot]) | ($urandom & ~plan_mask[slot]);
        if (r < 10) addr = addr ^ (32'h1 << $urandom_range(0, 31));
        else if (r < 25) addr = $urandom;
        queue_lookup(addr);
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (words_taken < words_total || route_answers_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
